>>> rtl/vnorm_pkg.sv
// Shared types and constants for the vector normalize unit.
// No dependencies; used by every module in rtl/.
`timescale 1ns / 1ps

package vnorm_pkg;

   localparam int LANES = 3;

   typedef struct packed {
      logic             valid;
      logic [LANES-1:0] neg;
   } vnorm_ctrl_type;

endpackage

>>> rtl/vnorm_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per item.
// Depends on vnorm_pkg.
`timescale 1ns / 1ps

module vnorm_sqrt_cell #(
   parameter int W  = 24,
   parameter int PW = 120
) (
   input  logic                     clock,
   input  logic                     reset,
   input  vnorm_pkg::vnorm_ctrl_type src_ctrl,
   input  logic [W:0]               src_rem,
   input  logic [W-1:0]             src_root,
   input  logic [2*W-1:0]           src_rad,
   input  logic [PW-1:0]            src_pass,
   output vnorm_pkg::vnorm_ctrl_type dst_ctrl,
   output logic [W:0]               dst_rem,
   output logic [W-1:0]             dst_root,
   output logic [2*W-1:0]           dst_rad,
   output logic [PW-1:0]            dst_pass
);

   vnorm_pkg::vnorm_ctrl_type ctrl_ff;
   logic [W:0]     rem_ff, rem_in;
   logic [W-1:0]   root_ff, root_in;
   logic [2*W-1:0] rad_ff, rad_in;
   logic [PW-1:0]  pass_ff;
   logic [W+2:0]   cur, trial, diff;
   logic           ge;

   always_comb begin
      cur     = {src_rem, src_rad[2*W-1 -: 2]};
      trial   = {1'b0, src_root, 2'b01};
      diff    = cur - trial;
      ge      = (cur >= trial);
      rem_in  = ge ? diff[W:0] : cur[W:0];
      root_in = {src_root[W-2:0], ge};
      rad_in  = {src_rad[2*W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= src_ctrl;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      rad_ff  <= rad_in;
      pass_ff <= src_pass;
   end

   assign dst_ctrl = ctrl_ff;
   assign dst_rem  = rem_ff;
   assign dst_root = root_ff;
   assign dst_rad  = rad_ff;
   assign dst_pass = pass_ff;

endmodule

>>> rtl/vnorm_div_cell.sv
// One cell of the divide chain: settles one quotient bit for each lane.
// Depends on vnorm_pkg.
`timescale 1ns / 1ps

module vnorm_div_cell #(
   parameter int W     = 24,
   parameter int F     = 22,
   parameter int FIRST = 0
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  vnorm_pkg::vnorm_ctrl_type                 src_ctrl,
   input  logic [vnorm_pkg::LANES-1:0][W-1:0]       src_rem,
   input  logic [vnorm_pkg::LANES-1:0][F:0]         src_q,
   input  logic [W-1:0]                             src_den,
   input  logic [2*W-1:0]                           src_sum,
   output vnorm_pkg::vnorm_ctrl_type                 dst_ctrl,
   output logic [vnorm_pkg::LANES-1:0][W-1:0]       dst_rem,
   output logic [vnorm_pkg::LANES-1:0][F:0]         dst_q,
   output logic [W-1:0]                             dst_den,
   output logic [2*W-1:0]                           dst_sum
);

   vnorm_pkg::vnorm_ctrl_type                 ctrl_ff;
   logic [vnorm_pkg::LANES-1:0][W-1:0]        rem_ff, rem_in;
   logic [vnorm_pkg::LANES-1:0][F:0]          q_ff, q_in;
   logic [W-1:0]                              den_ff;
   logic [2*W-1:0]                            sum_ff;
   logic [W:0]                                cur, diff;
   logic                                      ge;

   always_comb begin
      rem_in = '0;
      q_in   = '0;
      cur    = '0;
      diff   = '0;
      ge     = 1'b0;
      for (int i = 0; i < vnorm_pkg::LANES; i++) begin
         if (FIRST != 0) begin
            cur = {1'b0, src_rem[i]};
         end else begin
            cur = {src_rem[i], 1'b0};
         end
         diff      = cur - {1'b0, src_den};
         ge        = (cur >= {1'b0, src_den});
         rem_in[i] = ge ? diff[W-1:0] : cur[W-1:0];
         q_in[i]   = {src_q[i][F-1:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= src_ctrl;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= src_den;
      sum_ff <= src_sum;
   end

   assign dst_ctrl = ctrl_ff;
   assign dst_rem  = rem_ff;
   assign dst_q    = q_ff;
   assign dst_den  = den_ff;
   assign dst_sum  = sum_ff;

endmodule

>>> rtl/vector3_normalize_unit.sv
// Top level of the vector normalize unit.
// Depends on vnorm_pkg, vnorm_sqrt_cell and vnorm_div_cell.
//
// Usage:
//   Raise start with req_vec_x/y/z; the item is taken at that edge since
//   busy is never raised. One item may be given in every cycle.
//   Each result appears for one cycle with rsp_valid high and carries the
//   unit vector, the truncated length, the squared length and the zero
//   vector flag. Results leave in the order items came in.
//   Items pass through the magnitude, squares and sum registers, one cell
//   per root bit in the square root chain, one cell per quotient bit in
//   the divide chain, and the output register.
//   Throughput is one item per cycle, since no cell or register ever stalls.
//   Reset clears all valid bits; items in flight are dropped.
//   The receiver cannot stall; results must be taken as they appear.
`timescale 1ns / 1ps

module vector3_normalize_unit #(
   parameter int COMPONENT_WIDTH    = 24,
   parameter int UNIT_FRACTION_BITS = 22
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [COMPONENT_WIDTH-1:0]    req_vec_x,
   input  logic signed [COMPONENT_WIDTH-1:0]    req_vec_y,
   input  logic signed [COMPONENT_WIDTH-1:0]    req_vec_z,
   output logic                                 rsp_valid,
   output logic signed [UNIT_FRACTION_BITS+1:0] rsp_unit_x,
   output logic signed [UNIT_FRACTION_BITS+1:0] rsp_unit_y,
   output logic signed [UNIT_FRACTION_BITS+1:0] rsp_unit_z,
   output logic [COMPONENT_WIDTH-1:0]           rsp_magnitude,
   output logic [2*COMPONENT_WIDTH-1:0]         rsp_magnitude_squared,
   output logic                                 rsp_zero_vector
);

   localparam int W  = COMPONENT_WIDTH;
   localparam int F  = UNIT_FRACTION_BITS;
   localparam int L  = vnorm_pkg::LANES;
   localparam int PW = L * W + 2 * W;
   localparam int UW = F + 2;

   logic [L-1:0][W-1:0]       vec;
   vnorm_pkg::vnorm_ctrl_type ctrl1_ff, ctrl2_ff, ctrl3_ff;
   logic [L-1:0][W-1:0]       mag1_ff, mag2_ff, mag3_ff;
   logic [L-1:0][2*W-1:0]     sq2_ff;
   logic [2*W-1:0]            sum3_ff;

   vnorm_pkg::vnorm_ctrl_type s_ctrl [0:W];
   logic [W:0]                s_rem  [0:W];
   logic [W-1:0]              s_root [0:W];
   logic [2*W-1:0]            s_rad  [0:W];
   logic [PW-1:0]             s_pass [0:W];

   vnorm_pkg::vnorm_ctrl_type d_ctrl [0:F+1];
   logic [L-1:0][W-1:0]       d_rem  [0:F+1];
   logic [L-1:0][F:0]         d_q    [0:F+1];
   logic [W-1:0]              d_den  [0:F+1];
   logic [2*W-1:0]            d_sum  [0:F+1];

   logic                      valid_ff;
   logic [L-1:0][UW-1:0]      unit_ff, unit_in;
   logic [W-1:0]              mag_ff;
   logic [2*W-1:0]            sumsq_ff;
   logic                      zero_ff, zero_in;

   assign busy = 1'b0;
   assign vec  = {req_vec_z, req_vec_y, req_vec_x};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl1_ff <= '0;
         ctrl2_ff <= '0;
         ctrl3_ff <= '0;
      end else begin
         ctrl1_ff.valid <= start;
         for (int i = 0; i < L; i++) begin
            ctrl1_ff.neg[i] <= vec[i][W-1];
         end
         ctrl2_ff <= ctrl1_ff;
         ctrl3_ff <= ctrl2_ff;
      end
      for (int i = 0; i < L; i++) begin
         mag1_ff[i] <= vec[i][W-1] ? (~vec[i] + 1'b1) : vec[i];
         sq2_ff[i]  <= {{W{1'b0}}, mag1_ff[i]} * {{W{1'b0}}, mag1_ff[i]};
      end
      mag2_ff <= mag1_ff;
      mag3_ff <= mag2_ff;
      sum3_ff <= sq2_ff[0] + sq2_ff[1] + sq2_ff[2];
   end

   assign s_ctrl[0] = ctrl3_ff;
   assign s_rem[0]  = '0;
   assign s_root[0] = '0;
   assign s_rad[0]  = sum3_ff;
   assign s_pass[0] = {sum3_ff, mag3_ff};

   for (genvar k = 0; k < W; k++) begin : g_sqrt
      vnorm_sqrt_cell #(
         .W  (W),
         .PW (PW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .src_ctrl (s_ctrl[k]),
         .src_rem  (s_rem[k]),
         .src_root (s_root[k]),
         .src_rad  (s_rad[k]),
         .src_pass (s_pass[k]),
         .dst_ctrl (s_ctrl[k+1]),
         .dst_rem  (s_rem[k+1]),
         .dst_root (s_root[k+1]),
         .dst_rad  (s_rad[k+1]),
         .dst_pass (s_pass[k+1])
      );
   end

   assign d_ctrl[0] = s_ctrl[W];
   assign d_rem[0]  = s_pass[W][L*W-1:0];
   assign d_q[0]    = '0;
   assign d_den[0]  = s_root[W];
   assign d_sum[0]  = s_pass[W][PW-1:L*W];

   for (genvar k = 0; k <= F; k++) begin : g_div
      vnorm_div_cell #(
         .W     (W),
         .F     (F),
         .FIRST ((k == 0) ? 1 : 0)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .src_ctrl (d_ctrl[k]),
         .src_rem  (d_rem[k]),
         .src_q    (d_q[k]),
         .src_den  (d_den[k]),
         .src_sum  (d_sum[k]),
         .dst_ctrl (d_ctrl[k+1]),
         .dst_rem  (d_rem[k+1]),
         .dst_q    (d_q[k+1]),
         .dst_den  (d_den[k+1]),
         .dst_sum  (d_sum[k+1])
      );
   end

   always_comb begin
      zero_in = (d_den[F+1] == '0);
      unit_in = '0;
      for (int i = 0; i < L; i++) begin
         if (!zero_in) begin
            if (d_ctrl[F+1].neg[i]) begin
               unit_in[i] = ~{1'b0, d_q[F+1][i]} + 1'b1;
            end else begin
               unit_in[i] = {1'b0, d_q[F+1][i]};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= d_ctrl[F+1].valid;
      end
      unit_ff  <= unit_in;
      mag_ff   <= d_den[F+1];
      sumsq_ff <= d_sum[F+1];
      zero_ff  <= zero_in;
   end

   assign rsp_valid             = valid_ff;
   assign rsp_unit_x            = unit_ff[0];
   assign rsp_unit_y            = unit_ff[1];
   assign rsp_unit_z            = unit_ff[2];
   assign rsp_magnitude         = mag_ff;
   assign rsp_magnitude_squared = sumsq_ff;
   assign rsp_zero_vector       = zero_ff;

   a_zero_clears : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_vector |->
         rsp_unit_x == '0 && rsp_unit_y == '0 && rsp_unit_z == '0
         && rsp_magnitude_squared == '0)
      else $error("zero vector item with nonzero fields");

   a_root_low : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ({{W{1'b0}}, rsp_magnitude} * {{W{1'b0}}, rsp_magnitude}) <= rsp_magnitude_squared)
      else $error("length squared exceeds squared length");

   a_quot_bound : assert property (@(posedge clock) disable iff (reset)
      d_ctrl[F+1].valid && d_den[F+1] != '0 |->
         d_q[F+1][0] <= {1'b1, {F{1'b0}}} && d_q[F+1][1] <= {1'b1, {F{1'b0}}}
         && d_q[F+1][2] <= {1'b1, {F{1'b0}}})
      else $error("unit component above one");

endmodule
